// ----- rtl/core/fmv_pkg.sv -----
// fmv_pkg: shared types and constants of the three-operator fm voice
// register indexes, wave and route codes, polynomial coefficients, config struct
// no dependencies
package fmv_pkg;

	localparam int CFG_IDX_BITS = 4;

	localparam logic [CFG_IDX_BITS-1:0] REG_FREQ_ONE    = 4'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_FREQ_TWO    = 4'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_FREQ_THREE  = 4'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_START_LEVEL = 4'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_DECAY_STEP  = 4'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_WAVE_SELECT = 4'd5;
	localparam logic [CFG_IDX_BITS-1:0] REG_ROUTE_MODE  = 4'd6;
	localparam logic [CFG_IDX_BITS-1:0] REG_MOD_DEPTH   = 4'd7;

	localparam logic [31:0] RST_FREQ_ONE    = 32'd3895662;
	localparam logic [31:0] RST_FREQ_TWO    = 32'd7791324;
	localparam logic [31:0] RST_FREQ_THREE  = 32'd3895662;
	localparam logic [30:0] RST_START_LEVEL = 31'd3276800;
	localparam logic [30:0] RST_DECAY_STEP  = 31'd7;
	localparam logic [5:0]  RST_WAVE_SELECT = 6'd0;
	localparam logic [1:0]  RST_ROUTE_MODE  = 2'd0;
	localparam logic [31:0] RST_MOD_DEPTH   = 32'd6553600;

	localparam logic [1:0] WAVE_COS     = 2'd0;
	localparam logic [1:0] WAVE_SQUARE  = 2'd1;
	localparam logic [1:0] WAVE_TRI     = 2'd2;
	// code three reads as a cosine
	localparam logic [1:0] WAVE_COS_ALT = 2'd3;

	localparam logic [1:0] ROUTE_ONE_TWO   = 2'd0;
	localparam logic [1:0] ROUTE_CHAIN     = 2'd1;
	localparam logic [1:0] ROUTE_SUM       = 2'd2;
	localparam logic [1:0] ROUTE_ONE_ALONE = 2'd3;

	// quarter-wave cosine polynomial, q30
	localparam logic [30:0] Q30_ONE = 31'h4000_0000;
	localparam logic [31:0] COEF_A  = 32'd1324675879;
	localparam logic [31:0] COEF_B  = 32'd272375560;
	localparam logic [31:0] COEF_C  = 32'd22401992;
	localparam logic [31:0] COEF_D  = 32'd987048;
	// 1 / (2 pi) in q32
	localparam logic [31:0] INV_TWO_PI = 32'd683565276;

	// signed q16 wave value, range -65536 to 65536
	typedef logic signed [17:0] wave_t;

	typedef struct packed {
		logic [31:0]        freq_one;
		logic [31:0]        freq_two;
		logic [31:0]        freq_three;
		logic [30:0]        start_level;
		logic [30:0]        decay_step;
		logic [5:0]         wave_select;
		logic [1:0]         route_mode;
		logic signed [31:0] mod_depth;
	} cfg_t;

	typedef struct packed {
		logic        issue;
		logic [31:0] a;
		logic [31:0] b;
	} mul_req_t;

endpackage

// ----- rtl/core/fmv_if.sv -----
// fmv_if: valid/ready channels of the fm voice (trigger beats, sample beats, config writes)
// depends on fmv_pkg for the config index width
interface fmv_in_if;
	logic valid;
	logic ready;
	logic retrigger;

	modport source (output valid, output retrigger, input ready);
	modport sink (input valid, input retrigger, output ready);
endinterface

interface fmv_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

interface fmv_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [fmv_pkg::CFG_IDX_BITS-1:0] index;
	logic [31:0]                       data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/fmv_mul.sv -----
// fmv_mul: shared 32x32 unsigned multiplier with registered product
// depends on fmv_pkg for the request struct
module fmv_mul (
	input  logic              clk,
	input  fmv_pkg::mul_req_t req,
	output logic [63:0]       prod
);
	import fmv_pkg::*;

	// product holds until the next issue
	always_ff @(posedge clk) begin
		if (req.issue) begin
			prod <= req.a * req.b;
		end
	end

endmodule

// ----- rtl/core/fmv_cfg_regs.sv -----
// fmv_cfg_regs: configuration register file of the fm voice
// depends on fmv_pkg and the fmv_cfg_if channel
module fmv_cfg_regs (
	input  logic            clk,
	input  logic            arst_n,
	fmv_cfg_if.sink         cfg,
	output fmv_pkg::cfg_t   regs
);
	import fmv_pkg::*;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs.freq_one    <= RST_FREQ_ONE;
			regs.freq_two    <= RST_FREQ_TWO;
			regs.freq_three  <= RST_FREQ_THREE;
			regs.start_level <= RST_START_LEVEL;
			regs.decay_step  <= RST_DECAY_STEP;
			regs.wave_select <= RST_WAVE_SELECT;
			regs.route_mode  <= RST_ROUTE_MODE;
			regs.mod_depth   <= RST_MOD_DEPTH;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_FREQ_ONE:    regs.freq_one    <= cfg.data;
				REG_FREQ_TWO:    regs.freq_two    <= cfg.data;
				REG_FREQ_THREE:  regs.freq_three  <= cfg.data;
				REG_START_LEVEL: regs.start_level <= cfg.data[30:0];
				REG_DECAY_STEP:  regs.decay_step  <= cfg.data[30:0];
				REG_WAVE_SELECT: regs.wave_select <= cfg.data[5:0];
				REG_ROUTE_MODE:  regs.route_mode  <= cfg.data[1:0];
				REG_MOD_DEPTH:   regs.mod_depth   <= cfg.data;
				default: ;
			endcase
		end
	end

endmodule

// ----- rtl/core/fm_three_operator_voice.sv -----
// fm_three_operator_voice: three-operator fm voice, one signed 16-bit sample per trigger beat
// the sample register loads after the operator steps and the envelope product; a triangle
// operator skips the polynomial steps, and when modulated also the high offset and sum steps
// the next trigger beat is taken only after the sample register loads, which waits for a free
// output, with the single shared 32x32 multiplier doing up to 22 products per sample
// reset: phases to zero, envelope to the start level reset value, registers to defaults
module fm_three_operator_voice #(
	parameter int PHASE_BITS      = 32,
	parameter int WAVE_TABLE_BITS = 10
) (
	input  logic       clk,
	input  logic       arst_n,
	fmv_in_if.sink     events,
	fmv_out_if.source  samples,
	fmv_cfg_if.sink    cfg
);
	import fmv_pkg::*;

	localparam int W    = WAVE_TABLE_BITS;
	localparam int XSH  = 32 - W;
	localparam int TSH  = 18 - W;
	localparam logic [W-1:0] HALF = W'(1) << (W - 1);

	typedef enum logic [3:0] {
		ST_IDLE, ST_THETA, ST_OFF_LO, ST_OFF_HI, ST_OFF_SUM, ST_INDEX, ST_SHAPE,
		ST_P0, ST_P1, ST_P2, ST_P3, ST_P4, ST_ENV, ST_OUT
	} state_t;

	cfg_t     cfg_q;
	mul_req_t mul_req;
	logic [63:0] mul_prod;

	state_t                state_q;
	logic [1:0]            osc_q;
	logic [PHASE_BITS-1:0] phase_one_q, phase_two_q, phase_three_q;
	logic [30:0]           env_q;

	wave_t              c1_q;
	wave_t              fin_q;
	logic signed [18:0] modsum_q;
	logic               theta_neg_q;
	logic [24:0]        m_hi_q;
	logic [53:0]        acc_q;
	logic [31:0]        offset_q;
	logic [W-1:0]       k_q;
	logic [30:0]        x2_q;

	fmv_cfg_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (cfg_q)
	);

	fmv_mul u_mul (
		.clk  (clk),
		.req  (mul_req),
		.prod (mul_prod)
	);

	// current operator selection
	logic [1:0]            sel;
	logic [PHASE_BITS-1:0] ph_cur;
	logic [PHASE_BITS+31:0] ph_ext;
	logic [31:0]           ph32;

	always_comb begin
		case (osc_q)
			2'd0: begin
				sel    = cfg_q.wave_select[1:0];
				ph_cur = phase_one_q;
			end
			2'd1: begin
				sel    = cfg_q.wave_select[3:2];
				ph_cur = phase_two_q;
			end
			default: begin
				sel    = cfg_q.wave_select[5:4];
				ph_cur = phase_three_q;
			end
		endcase
		ph_ext = {ph_cur, 32'b0};
		ph32   = ph_ext[PHASE_BITS+31 -: 32];
	end

	// envelope update on a trigger beat
	logic [30:0] env_load, env_next;
	assign env_load = events.retrigger ? cfg_q.start_level : env_q;
	assign env_next = (env_load > cfg_q.decay_step) ? env_load - cfg_q.decay_step : '0;

	// magnitudes feeding the multiplier
	logic [31:0]        md_mag;
	logic signed [18:0] modsum_neg;
	logic [17:0]        modsum_mag;
	wave_t              fin_neg;
	logic [16:0]        fin_mag;
	assign md_mag     = cfg_q.mod_depth[31] ? 32'(-cfg_q.mod_depth) : cfg_q.mod_depth;
	assign modsum_neg = -modsum_q;
	assign modsum_mag = modsum_q[18] ? modsum_neg[17:0] : modsum_q[17:0];
	assign fin_neg    = -fin_q;
	assign fin_mag    = fin_q[17] ? fin_neg[16:0] : fin_q[16:0];

	// offset pieces
	logic [31:0] sh30;
	logic [31:0] tri_off_mag, cos_off;
	logic [63:0] off_sum;
	assign sh30        = mul_prod[61:30];
	assign tri_off_mag = mul_prod[31:0];
	assign off_sum     = {10'b0, acc_q} + {mul_prod[39:0], 24'b0};
	assign cos_off     = off_sum[63:32];

	// table index, quadrant fraction and triangle
	logic [31:0]        total;
	logic [1:0]         quad;
	logic [30:0]        x_raw, x_val;
	logic [W-1:0]       tri_ad;
	logic [17:0]        tri_sh;
	logic signed [18:0] tri_wide;
	wave_t              tri_val;
	assign total    = ph32 + offset_q;
	assign quad     = k_q[W-1 -: 2];
	assign x_raw    = 31'(k_q[W-3:0]) << XSH;
	assign x_val    = quad[0] ? Q30_ONE - x_raw : x_raw;
	assign tri_ad   = k_q[W-1] ? k_q - HALF : HALF - k_q;
	assign tri_sh   = 18'(tri_ad) << TSH;
	assign tri_wide = 19'sd65536 - $signed({1'b0, tri_sh});
	assign tri_val  = 18'(tri_wide);

	// cosine / square from the last polynomial product
	logic [30:0] qc;
	logic [31:0] qc_rnd;
	wave_t       cos_pos, cos_val, sq_val;
	always_comb begin
		qc      = (sh30 < 32'(Q30_ONE)) ? Q30_ONE - 31'(sh30) : '0;
		qc_rnd  = 32'(qc) + 32'd8192;
		cos_pos = $signed({1'b0, qc_rnd[30:14]});
		cos_val = (quad inside {2'd1, 2'd2}) ? -cos_pos : cos_pos;
		sq_val  = (cos_val[17] || cos_val == '0) ? -18'sd65536 : 18'sd65536;
	end

	logic  wave_done;
	wave_t w_val;
	assign wave_done = (state_q == ST_SHAPE && sel == WAVE_TRI) || state_q == ST_P4;
	assign w_val     = (state_q == ST_SHAPE) ? tri_val :
	                   (sel == WAVE_SQUARE) ? sq_val : cos_val;

	// multiplier requests
	always_comb begin
		mul_req = '0;
		case (state_q)
			ST_THETA: begin
				mul_req = '{1'b1, md_mag, 32'(modsum_mag)};
			end
			ST_OFF_LO: begin
				if (sel != WAVE_TRI) begin
					mul_req = '{1'b1, 32'(mul_prod[23:0]), INV_TWO_PI};
				end
			end
			ST_OFF_HI: mul_req = '{1'b1, 32'(m_hi_q), INV_TWO_PI};
			ST_SHAPE: begin
				if (sel != WAVE_TRI) begin
					mul_req = '{1'b1, 32'(x_val), 32'(x_val)};
				end
			end
			ST_P0: mul_req = '{1'b1, COEF_D, 32'(mul_prod[60:30])};
			ST_P1: mul_req = '{1'b1, COEF_C - sh30, 32'(x2_q)};
			ST_P2: mul_req = '{1'b1, COEF_B - sh30, 32'(x2_q)};
			ST_P3: mul_req = '{1'b1, COEF_A - sh30, 32'(x2_q)};
			ST_ENV: mul_req = '{1'b1, 32'(env_q), 32'(fin_mag)};
			default: ;
		endcase
	end

	assign events.ready = (state_q == ST_IDLE);

	logic        out_free;
	logic [15:0] smp_mag;
	assign out_free = !samples.valid || samples.ready;
	assign smp_mag  = {1'b0, mul_prod[46:32]};

	// sequencer, phases, envelope and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			osc_q          <= 2'd0;
			phase_one_q    <= '0;
			phase_two_q    <= '0;
			phase_three_q  <= '0;
			env_q          <= RST_START_LEVEL;
			samples.valid  <= 1'b0;
			samples.sample <= '0;
		end else begin
			// in the output state the load below decides valid
			if (samples.valid && samples.ready && state_q != ST_OUT) begin
				samples.valid <= 1'b0;
			end
			if (wave_done) begin
				case (osc_q)
					2'd0: begin
						if (cfg_q.route_mode == ROUTE_ONE_ALONE) begin
							state_q <= ST_ENV;
						end else begin
							osc_q   <= 2'd1;
							state_q <= (cfg_q.route_mode == ROUTE_SUM) ? ST_INDEX : ST_THETA;
						end
					end
					2'd1: begin
						if (cfg_q.route_mode == ROUTE_CHAIN || cfg_q.route_mode == ROUTE_SUM) begin
							osc_q   <= 2'd2;
							state_q <= ST_THETA;
						end else begin
							state_q <= ST_ENV;
						end
					end
					default: state_q <= ST_ENV;
				endcase
			end else begin
				case (state_q)
					ST_IDLE: begin
						if (events.valid) begin
							phase_one_q   <= phase_one_q + PHASE_BITS'(cfg_q.freq_one);
							phase_two_q   <= phase_two_q + PHASE_BITS'(cfg_q.freq_two);
							phase_three_q <= phase_three_q + PHASE_BITS'(cfg_q.freq_three);
							env_q         <= env_next;
							osc_q         <= 2'd0;
							state_q       <= ST_INDEX;
						end
					end
					ST_THETA:   state_q <= ST_OFF_LO;
					ST_OFF_LO:  state_q <= (sel == WAVE_TRI) ? ST_INDEX : ST_OFF_HI;
					ST_OFF_HI:  state_q <= ST_OFF_SUM;
					ST_OFF_SUM: state_q <= ST_INDEX;
					ST_INDEX:   state_q <= ST_SHAPE;
					ST_SHAPE:   state_q <= ST_P0;
					ST_P0:      state_q <= ST_P1;
					ST_P1:      state_q <= ST_P2;
					ST_P2:      state_q <= ST_P3;
					ST_P3:      state_q <= ST_P4;
					ST_ENV:     state_q <= ST_OUT;
					ST_OUT: begin
						// hold the result until the sample register is free
						if (out_free) begin
							samples.valid  <= 1'b1;
							samples.sample <= fin_q[17] ? 16'd0 - smp_mag : smp_mag;
							state_q        <= ST_IDLE;
						end else begin
							samples.valid  <= 1'b1;
						end
					end
					default: state_q <= ST_IDLE;
				endcase
			end
		end
	end

	// datapath holding registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			offset_q <= '0;
		end
		if (wave_done) begin
			fin_q <= w_val;
			if (osc_q == 2'd0) begin
				c1_q     <= w_val;
				modsum_q <= 19'(w_val);
				offset_q <= '0;
			end else if (cfg_q.route_mode == ROUTE_SUM) begin
				modsum_q <= 19'(w_val) + 19'(c1_q);
			end else begin
				modsum_q <= 19'(w_val);
			end
		end
		case (state_q)
			ST_THETA: theta_neg_q <= cfg_q.mod_depth[31] ^ modsum_q[18];
			ST_OFF_LO: begin
				m_hi_q <= mul_prod[48:24];
				// triangle offset is the raw product modulo one phase turn
				if (sel == WAVE_TRI) begin
					offset_q <= theta_neg_q ? 32'd0 - tri_off_mag : tri_off_mag;
				end
			end
			ST_OFF_HI:  acc_q    <= mul_prod[53:0];
			ST_OFF_SUM: offset_q <= theta_neg_q ? 32'd0 - cos_off : cos_off;
			ST_INDEX:   k_q      <= total[31 -: W];
			ST_P0:      x2_q     <= mul_prod[60:30];
			default: ;
		endcase
	end

	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(events.valid && events.ready) |=> !events.ready)
		else $error("trigger taken while an item is in work");

	a_sample_bound: assert property (@(posedge clk) disable iff (!arst_n)
		samples.valid |-> (samples.sample != 16'sh8000))
		else $error("sample magnitude beyond envelope bound");

	a_env_decays: assert property (@(posedge clk) disable iff (!arst_n)
		(events.valid && events.ready && !events.retrigger) |=> (env_q <= $past(env_q)))
		else $error("envelope rose without retrigger");

	a_route_one_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ENV) |-> (osc_q != 2'd0 || cfg_q.route_mode == ROUTE_ONE_ALONE))
		else $error("operator one reached the envelope in a modulated route");

	a_theta_modulated: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_THETA) |-> (osc_q != 2'd0 && osc_q != 2'd3))
		else $error("modulation term computed for a carrier-free operator");

endmodule
